// ===== rtl/r2y420_pkg.sv =====
package r2y420_pkg;

	localparam int COMP_W       = 8;
	localparam int LUMA_OFF_W   = 24;
	localparam int CHROMA_OFF_W = 22;
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 1;
	localparam int TERM_W       = 6;
	localparam int PAIR_W       = 7;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [15:0] Y_KR = 16'd66;
	localparam logic [15:0] Y_KG = 16'd129;
	localparam logic [15:0] Y_KB = 16'd25;
	localparam logic [7:0]  Y_OFS = 8'd16;

	localparam logic signed [16:0] U_KR = -17'sd38;
	localparam logic signed [16:0] U_KG = -17'sd74;
	localparam logic signed [16:0] U_KB = 17'sd112;
	localparam logic signed [16:0] V_KR = 17'sd112;
	localparam logic signed [16:0] V_KG = -17'sd94;
	localparam logic signed [16:0] V_KB = -17'sd18;
	localparam logic signed [16:0] RND = 17'sd128;
	localparam logic signed [8:0]  C_OFS = 9'sd128;

	function automatic logic [COMP_W-1:0] luma_of(
		input logic [COMP_W-1:0] r,
		input logic [COMP_W-1:0] g,
		input logic [COMP_W-1:0] b
	);
		logic [15:0] acc;
		acc = Y_KR * {8'd0, r} + Y_KG * {8'd0, g} + Y_KB * {8'd0, b} + 16'd128;
		return acc[15:8] + Y_OFS;
	endfunction

	function automatic logic [TERM_W-1:0] chroma_term(
		input logic [COMP_W-1:0] r,
		input logic [COMP_W-1:0] g,
		input logic [COMP_W-1:0] b,
		input logic signed [16:0] kr,
		input logic signed [16:0] kg,
		input logic signed [16:0] kb
	);
		logic signed [16:0] acc;
		logic signed [8:0]  sum;
		acc = kr * $signed({9'd0, r}) + kg * $signed({9'd0, g})
			+ kb * $signed({9'd0, b}) + RND;
		sum = $signed(acc[16:8]) + C_OFS;
		return sum[7:2];
	endfunction

endpackage

// ===== rtl/r2y420_ifs.sv =====
interface r2y420_pix_if;
	logic                             valid;
	logic                             ready;
	logic [r2y420_pkg::COMP_W-1:0] red;
	logic [r2y420_pkg::COMP_W-1:0] green;
	logic [r2y420_pkg::COMP_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface r2y420_yuv_if;
	logic                                   valid;
	logic                                   ready;
	logic [r2y420_pkg::COMP_W-1:0]       luma;
	logic [r2y420_pkg::LUMA_OFF_W-1:0]   luma_offset;
	logic                                   chroma_valid;
	logic [r2y420_pkg::COMP_W-1:0]       chroma_u;
	logic [r2y420_pkg::COMP_W-1:0]       chroma_v;
	logic [r2y420_pkg::CHROMA_OFF_W-1:0] chroma_offset;
	logic                                   frame_done;

	modport source (
		output valid, output luma, output luma_offset, output chroma_valid,
		output chroma_u, output chroma_v, output chroma_offset, output frame_done,
		input ready
	);
	modport sink (
		input valid, input luma, input luma_offset, input chroma_valid,
		input chroma_u, input chroma_v, input chroma_offset, input frame_done,
		output ready
	);
endinterface

// ===== rtl/rgb_to_yuv420p_raster.sv =====
// Converts a raster stream of 8-bit RGB pixels to BT.601 YUV 4:2:0 planar samples, one
// result beat per pixel. It takes one pixel per clock while the result side is not stalled; each
// pixel is registered in the s1 stage, then in the s2 stage, and is offered as a result from s2.
// A stalled result blocks the input only once both pipeline stages are full. The line store
// has one write port and one read port, so it never holds up the stream. Every beat carries
// the pixel's luma and its Y-plane offset. The bottom-right pixel of each 2x2 block also
// carries U, V and the chroma-plane offset, with the block's even-row pair sums kept in a
// line store of MAX_WIDTH/2 entries.
// The store needs no clearing pass after reset. Frame width and height are forced even and
// clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT; write them only while the block is idle.
module rgb_to_yuv420p_raster #(
	parameter int MAX_WIDTH  = r2y420_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = r2y420_pkg::DEF_MAX_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [r2y420_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [r2y420_pkg::CFG_W-1:0]       cfg_data,
	r2y420_pix_if.sink                         pixel,
	r2y420_yuv_if.source                       result
);

	localparam int CW        = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
	localparam int RW        = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int LineDepth = MAX_WIDTH / 2;
	localparam int AW        = (LineDepth > 1) ? $clog2(LineDepth) : 1;
	localparam int TW        = r2y420_pkg::TERM_W;
	localparam int PW        = r2y420_pkg::PAIR_W;
	localparam int LW        = r2y420_pkg::LUMA_OFF_W;
	localparam int KW        = r2y420_pkg::CHROMA_OFF_W;
	localparam int DW        = r2y420_pkg::COMP_W;
	localparam logic [13:0] MaxW = 14'(MAX_WIDTH & ~1);
	localparam logic [13:0] MaxH = 14'(MAX_HEIGHT & ~1);

	logic [r2y420_pkg::CFG_W-1:0] width_q;
	logic [r2y420_pkg::CFG_W-1:0] height_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [LW-1:0] luma_pos_q;
	logic [KW-1:0] chroma_pos_q;
	logic [PW-1:0] pair_u_q;
	logic [PW-1:0] pair_v_q;

	logic [2*PW-1:0] line_mem [LineDepth];

	logic            valid_s1;
	logic [DW-1:0]   red_s1;
	logic [DW-1:0]   green_s1;
	logic [DW-1:0]   blue_s1;
	logic            odd_col_s1;
	logic            odd_row_s1;
	logic            done_s1;
	logic [LW-1:0]   luma_off_s1;
	logic [KW-1:0]   chroma_off_s1;
	logic [AW-1:0]   idx_s1;
	logic [2*PW-1:0] line_s1;

	logic          valid_s2;
	logic [DW-1:0] luma_s2;
	logic [LW-1:0] luma_off_s2;
	logic          chroma_valid_s2;
	logic [DW-1:0] chroma_u_s2;
	logic [DW-1:0] chroma_v_s2;
	logic [KW-1:0] chroma_off_s2;
	logic          done_s2;

	logic [13:0]   w_even;
	logic [13:0]   h_even;
	logic [13:0]   w_clamp;
	logic [13:0]   h_clamp;
	logic [CW:0]   w_lim;
	logic [RW:0]   h_lim;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic          row_end;
	logic          frame_end;
	logic          emit_chroma;
	logic          in_acc;
	logic          out_free;
	logic          adv;
	logic [TW-1:0] term_u;
	logic [TW-1:0] term_v;
	logic [PW-1:0] sum_u;
	logic [PW-1:0] sum_v;
	logic          line_wr;

	always_comb begin
		w_even = {1'b0, width_q[r2y420_pkg::CFG_W-1:1], 1'b0};
		h_even = {1'b0, height_q[r2y420_pkg::CFG_W-1:1], 1'b0};
		w_clamp = w_even;
		if (w_even < 14'd2) begin
			w_clamp = 14'd2;
		end
		if (w_even > MaxW) begin
			w_clamp = MaxW;
		end
		h_clamp = h_even;
		if (h_even < 14'd2) begin
			h_clamp = 14'd2;
		end
		if (h_even > MaxH) begin
			h_clamp = MaxH;
		end
	end

	assign w_lim       = w_clamp[CW:0];
	assign h_lim       = h_clamp[RW:0];
	assign col_inc     = {1'b0, col_q} + 1'b1;
	assign row_inc     = {1'b0, row_q} + 1'b1;
	assign row_end     = col_inc >= w_lim;
	assign frame_end   = row_end && (row_inc >= h_lim);
	assign emit_chroma = col_q[0] && row_q[0];

	assign out_free    = !valid_s2 || result.ready;
	assign adv         = valid_s1 && out_free;
	assign pixel.ready = !valid_s1 || out_free;
	assign in_acc      = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= r2y420_pkg::RST_FRAME_WIDTH;
			height_q <= r2y420_pkg::RST_FRAME_HEIGHT;
		end else if (cfg_we) begin
			case (r2y420_pkg::cfg_reg_t'(cfg_index))
				r2y420_pkg::REG_FRAME_WIDTH: begin
					width_q <= cfg_data;
				end
				r2y420_pkg::REG_FRAME_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			luma_pos_q   <= '0;
			chroma_pos_q <= '0;
		end else if (in_acc) begin
			if (frame_end) begin
				col_q        <= '0;
				row_q        <= '0;
				luma_pos_q   <= '0;
				chroma_pos_q <= '0;
			end else begin
				luma_pos_q <= luma_pos_q + 1'b1;
				if (emit_chroma) begin
					chroma_pos_q <= chroma_pos_q + 1'b1;
				end
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			red_s1        <= pixel.red;
			green_s1      <= pixel.green;
			blue_s1       <= pixel.blue;
			odd_col_s1    <= col_q[0];
			odd_row_s1    <= row_q[0];
			done_s1       <= frame_end;
			luma_off_s1   <= luma_pos_q;
			chroma_off_s1 <= chroma_pos_q;
			idx_s1        <= col_q[AW:1];
		end
	end

	assign term_u  = r2y420_pkg::chroma_term(red_s1, green_s1, blue_s1,
		r2y420_pkg::U_KR, r2y420_pkg::U_KG, r2y420_pkg::U_KB);
	assign term_v  = r2y420_pkg::chroma_term(red_s1, green_s1, blue_s1,
		r2y420_pkg::V_KR, r2y420_pkg::V_KG, r2y420_pkg::V_KB);
	assign sum_u   = odd_col_s1 ? (pair_u_q + PW'(term_u)) : PW'(term_u);
	assign sum_v   = odd_col_s1 ? (pair_v_q + PW'(term_v)) : PW'(term_v);
	assign line_wr = adv && odd_col_s1 && !odd_row_s1;

	always_ff @(posedge clk) begin
		if (line_wr) begin
			line_mem[idx_s1] <= {sum_v, sum_u};
		end
		if (in_acc) begin
			line_s1 <= line_mem[col_q[AW:1]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_u_q <= '0;
			pair_v_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				pair_u_q <= sum_u;
				pair_v_q <= sum_v;
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			luma_s2     <= r2y420_pkg::luma_of(red_s1, green_s1, blue_s1);
			luma_off_s2 <= luma_off_s1;
			done_s2     <= done_s1;
			if (odd_col_s1 && odd_row_s1) begin
				chroma_valid_s2 <= 1'b1;
				chroma_u_s2     <= {1'b0, sum_u} + {1'b0, line_s1[PW-1:0]};
				chroma_v_s2     <= {1'b0, sum_v} + {1'b0, line_s1[2*PW-1:PW]};
				chroma_off_s2   <= chroma_off_s1;
			end else begin
				chroma_valid_s2 <= 1'b0;
				chroma_u_s2     <= '0;
				chroma_v_s2     <= '0;
				chroma_off_s2   <= '0;
			end
		end
	end

	assign result.valid         = valid_s2;
	assign result.luma          = luma_s2;
	assign result.luma_offset   = luma_off_s2;
	assign result.chroma_valid  = chroma_valid_s2;
	assign result.chroma_u      = chroma_u_s2;
	assign result.chroma_v      = chroma_v_s2;
	assign result.chroma_offset = chroma_off_s2;
	assign result.frame_done    = done_s2;

endmodule

// ===== rtl/r2y420_checker.sv =====
module r2y420_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [r2y420_pkg::COMP_W-1:0]       luma,
	input logic [r2y420_pkg::LUMA_OFF_W-1:0]   luma_offset,
	input logic                                   chroma_valid,
	input logic [r2y420_pkg::COMP_W-1:0]       chroma_u,
	input logic [r2y420_pkg::COMP_W-1:0]       chroma_v,
	input logic [r2y420_pkg::CHROMA_OFF_W-1:0] chroma_offset,
	input logic                                   frame_done
);

	logic after_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_done_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			after_done_q <= frame_done;
		end
	end

	// A stalled result beat stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (luma >= 8'd16) && (luma <= 8'd235))
		else $error("luma outside the video range");

	a_chroma_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |->
			(chroma_u == '0) && (chroma_v == '0) && (chroma_offset == '0))
		else $error("chroma fields set on a beat without chroma");

	// The first beat of every frame sits at the top-left of the Y plane.
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && after_done_q |-> (luma_offset == '0))
		else $error("frame did not restart at offset zero");

endmodule

bind rgb_to_yuv420p_raster r2y420_checker u_r2y420_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.luma          (result.luma),
	.luma_offset   (result.luma_offset),
	.chroma_valid  (result.chroma_valid),
	.chroma_u      (result.chroma_u),
	.chroma_v      (result.chroma_v),
	.chroma_offset (result.chroma_offset),
	.frame_done    (result.frame_done)
);
